[sv/sug_pkg.sv]
package sug_pkg;

  typedef struct packed {
    logic [10:0] id_type;
    logic [3:0]  machine_id;
    logic [31:0] time_token;
    logic [19:0] day_count;
  } sug_in_t;

  typedef struct packed {
    logic [63:0] id_value;
    logic [1:0]  status;
  } sug_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEQ,
    ST_SUM
  } sug_state_t;

  typedef enum logic [2:0] {
    KC_CONTRACT,
    KC_INVALID,
    KC_K98,
    KC_K99,
    KC_DEC,
    KC_PACK
  } sug_kind_class_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic seq_step;
    logic load_out;
  } sug_cmd_t;

  typedef struct packed {
    logic clear_last;
  } sug_stat_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_TYPE  = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  localparam logic [10:0] KIND_CONTRACT = 11'h4FF;
  localparam logic [10:0] KIND_SEC      = 11'd98;
  localparam logic [10:0] KIND_ROLL     = 11'd99;
  localparam logic [10:0] KIND_DEC0     = 11'd0;
  localparam logic [10:0] KIND_DEC1     = 11'd1;
  localparam logic [10:0] KIND_DEC2     = 11'd2;
  localparam logic [10:0] KIND_DEC50    = 11'd50;

  localparam int unsigned CNT_W = 14;
  localparam logic [CNT_W-1:0] DEC_LIMIT  = 14'd9999;
  localparam logic [CNT_W-1:0] PACK_LIMIT = 14'd16382;

  localparam logic [26:0] E8 = 27'd100000000;
  localparam logic [19:0] E6 = 20'd1000000;
  localparam logic [16:0] E5 = 17'd100000;
  localparam logic [13:0] E4 = 14'd10000;
  localparam logic [6:0]  SEQ_SCALE_DEC = 7'd100;
  localparam logic [3:0]  SEQ_SCALE_CON = 4'd10;

  // Width of the low decimal part: machine*1e6 + kind*1e4 + seq stays below 2^24.
  localparam int unsigned LOW_W = 24;

endpackage

[sv/sug_ctrl.sv]
module sug_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sug_pkg::sug_stat_t stat,
  output sug_pkg::sug_cmd_t  cmd
);

  sug_pkg::sug_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sug_pkg::ST_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = sug_pkg::ST_IDLE;
        end
      end
      sug_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sug_pkg::ST_SEQ;
        end
      end
      sug_pkg::ST_SEQ: begin
        state_nxt = sug_pkg::ST_SUM;
      end
      sug_pkg::ST_SUM: begin
        if (out_free) begin
          state_nxt = in_valid ? sug_pkg::ST_SEQ : sug_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sug_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sug_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      sug_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sug_pkg::ST_SEQ: begin
        cmd.seq_step = 1'b1;
      end
      sug_pkg::ST_SUM: begin
        // The finished id moves to the output register, which frees the
        // datapath for the next transfer in the same cycle.
        cmd.load_out = out_free;
        in_ready     = out_free;
        cmd.accept   = out_free && in_valid;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sug_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/sug_dpath.sv]
module sug_dpath #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sug_pkg::sug_cmd_t  cmd,
  output sug_pkg::sug_stat_t stat,
  input  sug_pkg::sug_in_t   in_data,
  output sug_pkg::sug_out_t  out_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [10:0] TABLE_LIMIT = 11'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [sug_pkg::CNT_W-1:0] ctr_mem [TABLE_ENTRIES];
  logic [sug_pkg::CNT_W-1:0] rd_data_r;

  sug_pkg::sug_in_t          item_r;
  sug_pkg::sug_out_t         out_r;
  logic [IDX_W-1:0]          clear_addr_r, clear_addr_nxt;
  logic [sug_pkg::CNT_W-1:0] contract_r, contract_nxt;
  logic [sug_pkg::CNT_W-1:0] c98_r, c98_nxt;
  logic [31:0]               last98_r, last98_nxt;
  logic [sug_pkg::CNT_W-1:0] c99_r, c99_nxt;
  logic [63:0]               term_a_r, term_a_nxt;
  logic [sug_pkg::LOW_W-1:0] term_b_r, term_b_nxt;
  logic [1:0]                status_r, status_nxt;

  sug_pkg::sug_kind_class_t  kcls;
  logic [10:0]               kind;
  logic [sug_pkg::CNT_W-1:0] old_cnt, lim, adv, seq98, seq;
  logic                      new_sec, exhausted;
  logic [58:0]               tok_prod;
  logic [36:0]               day_prod;
  logic [sug_pkg::LOW_W-1:0] mid_prod;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_wa;
  logic [sug_pkg::CNT_W-1:0] mem_wd;

  assign kind            = item_r.id_type;
  assign stat.clear_last = (clear_addr_r == LAST_IDX);
  assign out_data        = out_r;

  always_comb begin
    if (kind == sug_pkg::KIND_CONTRACT) begin
      kcls = sug_pkg::KC_CONTRACT;
    end else if (kind >= TABLE_LIMIT) begin
      kcls = sug_pkg::KC_INVALID;
    end else if (kind == sug_pkg::KIND_SEC) begin
      kcls = sug_pkg::KC_K98;
    end else if (kind == sug_pkg::KIND_ROLL) begin
      kcls = sug_pkg::KC_K99;
    end else if (kind == sug_pkg::KIND_DEC0 || kind == sug_pkg::KIND_DEC1 ||
                 kind == sug_pkg::KIND_DEC2 || kind == sug_pkg::KIND_DEC50) begin
      kcls = sug_pkg::KC_DEC;
    end else begin
      kcls = sug_pkg::KC_PACK;
    end
  end

  // Sequence selection: one wrapping increment shared by every counter but the kind-98 one.
  always_comb begin
    case (kcls)
      sug_pkg::KC_CONTRACT: old_cnt = contract_r;
      sug_pkg::KC_K99:      old_cnt = c99_r;
      default:              old_cnt = rd_data_r;
    endcase
    lim       = (kcls == sug_pkg::KC_PACK) ? sug_pkg::PACK_LIMIT : sug_pkg::DEC_LIMIT;
    adv       = (old_cnt >= lim) ? sug_pkg::CNT_W'(1) : old_cnt + sug_pkg::CNT_W'(1);
    new_sec   = (item_r.time_token != last98_r);
    exhausted = !new_sec && (c98_r >= sug_pkg::DEC_LIMIT);
    seq98     = new_sec ? '0 : c98_r + sug_pkg::CNT_W'(1);
    seq       = (kcls == sug_pkg::KC_K98) ? seq98 : adv;
  end

  always_comb begin
    tok_prod = 59'(item_r.time_token) * 59'(sug_pkg::E8);
    day_prod = 37'(item_r.day_count) * 37'(sug_pkg::E5);
    mid_prod = sug_pkg::LOW_W'(item_r.machine_id) * sug_pkg::LOW_W'(sug_pkg::E6);

    status_nxt = sug_pkg::STAT_OK;
    term_a_nxt = '0;
    term_b_nxt = '0;
    case (kcls)
      sug_pkg::KC_CONTRACT: begin
        term_a_nxt = 64'(day_prod);
        term_b_nxt = sug_pkg::LOW_W'(seq) * sug_pkg::LOW_W'(sug_pkg::SEQ_SCALE_CON)
                   + sug_pkg::LOW_W'(item_r.machine_id);
      end
      sug_pkg::KC_INVALID: begin
        status_nxt = sug_pkg::STAT_BAD_TYPE;
      end
      sug_pkg::KC_K98, sug_pkg::KC_K99: begin
        if (kcls == sug_pkg::KC_K98 && exhausted) begin
          status_nxt = sug_pkg::STAT_EXHAUSTED;
        end else begin
          term_a_nxt = 64'(tok_prod);
          term_b_nxt = mid_prod
                     + sug_pkg::LOW_W'(kind) * sug_pkg::LOW_W'(sug_pkg::E4)
                     + sug_pkg::LOW_W'(seq);
        end
      end
      sug_pkg::KC_DEC: begin
        term_a_nxt = 64'(tok_prod);
        term_b_nxt = mid_prod
                   + sug_pkg::LOW_W'(seq) * sug_pkg::LOW_W'(sug_pkg::SEQ_SCALE_DEC);
      end
      default: begin
        term_a_nxt = 64'({item_r.time_token, item_r.machine_id, kind[9:0], seq});
      end
    endcase
  end

  always_comb begin
    contract_nxt = contract_r;
    c98_nxt      = c98_r;
    last98_nxt   = last98_r;
    c99_nxt      = c99_r;
    if (cmd.seq_step) begin
      case (kcls)
        sug_pkg::KC_CONTRACT: contract_nxt = adv;
        sug_pkg::KC_K99:      c99_nxt      = adv;
        sug_pkg::KC_K98: begin
          if (new_sec) begin
            last98_nxt = item_r.time_token;
            c98_nxt    = '0;
          end else if (!exhausted) begin
            c98_nxt = seq98;
          end
        end
        default: begin
          contract_nxt = contract_r;
        end
      endcase
    end
  end

  always_comb begin
    clear_addr_nxt = clear_addr_r;
    if (cmd.clear_step && !stat.clear_last) begin
      clear_addr_nxt = clear_addr_r + IDX_W'(1);
    end
    if (cmd.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clear_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = cmd.seq_step && (kcls == sug_pkg::KC_DEC || kcls == sug_pkg::KC_PACK);
      mem_wa = kind[IDX_W-1:0];
      mem_wd = adv;
    end
  end

  // Counter table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ctr_mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_data_r <= ctr_mem[in_data.id_type[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.seq_step) begin
      term_a_r <= term_a_nxt;
      term_b_r <= term_b_nxt;
      status_r <= status_nxt;
    end
    if (cmd.load_out) begin
      out_r.id_value <= term_a_r + 64'(term_b_r);
      out_r.status   <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_addr_r <= '0;
      contract_r   <= '0;
      c98_r        <= '0;
      last98_r     <= '0;
      c99_r        <= '0;
    end else begin
      clear_addr_r <= clear_addr_nxt;
      contract_r   <= contract_nxt;
      c98_r        <= c98_nxt;
      last98_r     <= last98_nxt;
      c99_r        <= c99_nxt;
    end
  end

endmodule

[sv/sequenced_unique_id_generator.sv]
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    sug_in_t: id_type, machine_id, time_token, day_count
// out_     out  out_valid/out_ready  sug_out_t: id_value, status
//
// An item passes the counter table read-modify-write and the time product, then
// the final 64-bit add into the output register.
// After reset the counter table is cleared one entry a cycle, all TABLE_ENTRIES
// entries, and in_ready stays low until that pass ends.
// A result held in the output register does not block the next transfer in;
// the datapath stalls only when a second result is ready before the first left.
module sequenced_unique_id_generator #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sug_pkg::sug_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sug_pkg::sug_out_t out_data
);

  sug_pkg::sug_cmd_t  cmd;
  sug_pkg::sug_stat_t stat;

  sug_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sug_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == sug_pkg::STAT_OK || out_data.id_value == 64'd0))
    else $error("error result carries a nonzero id");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ready)
    else $error("input ready during the table clearing pass");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while its result is held");

  a_accept_then_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.seq_step)
    else $error("accepted item not followed by its sequence step");

endmodule
